@@ rtl/core/box_filter_3x3_edge_normalized_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box filter
// Two forms of a clocked implication: same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_3X3_EDGE_NORMALIZED_TOP_ASSERT_SVH
`define BOX_FILTER_3X3_EDGE_NORMALIZED_TOP_ASSERT_SVH

// consequent must hold in the cycle of the antecedent
`define BF3_ASSERT_IMPL(name, clk, rst, ante, cons) \
name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("bf3 assertion failed");

// consequent must hold in the cycle after the antecedent
`define BF3_ASSERT_NEXT(name, clk, rst, ante, cons) \
name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("bf3 assertion failed");

`endif

@@ rtl/core/bf3_pkg.sv @@
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared widths, divisor codes and reciprocal table of the 3x3 box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

   localparam int SIDE_W     = 11;
   localparam int COORD_W    = 10;
   localparam int COMP_W     = 16;
   localparam int SIDE_RESET = 1024;

   // mean = (sum * recip) >> RECIP_SHIFT, exact for sums below 2**21
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 24;

   typedef enum logic [2:0] {
      DIV_1 = 3'd0,
      DIV_2 = 3'd1,
      DIV_3 = 3'd2,
      DIV_4 = 3'd3,
      DIV_6 = 3'd4,
      DIV_9 = 3'd5
   } div_type;

   // position flags of one pixel inside the image
   typedef struct packed {
      logic r_ge1;
      logic r_ge2;
      logic c_ge1;
      logic c_ge2;
      logic r_last;
      logic c_last;
   } pos_type;

   // rows and cols are pixel counts of 1 to 3
   function automatic div_type div_code(input logic [1:0] rows, input logic [1:0] cols);
      div_type code;
      case ({rows, cols})
         4'b01_01:          code = DIV_1;
         4'b01_10, 4'b10_01: code = DIV_2;
         4'b01_11, 4'b11_01: code = DIV_3;
         4'b10_10:          code = DIV_4;
         4'b10_11, 4'b11_10: code = DIV_6;
         4'b11_11:          code = DIV_9;
         default:           code = DIV_1;
      endcase
      return code;
   endfunction

   function automatic logic [RECIP_W-1:0] recip_of(input div_type code);
      logic [RECIP_W-1:0] m;
      case (code)
         DIV_1:   m = 25'd16777216;
         DIV_2:   m = 25'd8388608;
         DIV_3:   m = 25'd5592406;
         DIV_4:   m = 25'd4194304;
         DIV_6:   m = 25'd2796203;
         DIV_9:   m = 25'd1864136;
         default: m = 25'd16777216;
      endcase
      return m;
   endfunction

endpackage

@@ rtl/core/box_filter_3x3_edge_normalized_top.sv @@
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_normalized_top
// 3x3 mean filter over a square RGB image in raster order, with the mean
// taken over the in-image part of each neighborhood.
//
//   port group   dir   handshake              carries
//   csr_*        in    csr_valid/csr_ready    image side length
//   req_*        in    req_valid/req_ready    one pixel (red, green, blue)
//   rsp_*        out   rsp_valid/rsp_ready    row, col, means, run_last, frame_done
//
// One item is accepted per cycle while req_ready is high. The result port
// moves one item per cycle while rsp_ready is high, so a pixel that completes
// two windows holds req_ready low longer, the bottom-right one longest. Line
// memory: one read at accept, one write as the item leaves stage 1. Reset is
// synchronous and needs no clearing pass; a side write restarts the frame. A
// stalled rsp fills the pipeline, then drops req_ready.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_normalized_top #(
   parameter int MAX_SIDE       = 1024,
   parameter int COMPONENT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bf3_pkg::SIDE_W-1:0]   csr_side_length,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bf3_pkg::COMP_W-1:0]   req_red,
   input  logic [bf3_pkg::COMP_W-1:0]   req_green,
   input  logic [bf3_pkg::COMP_W-1:0]   req_blue,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bf3_pkg::COORD_W-1:0]  rsp_row,
   output logic [bf3_pkg::COORD_W-1:0]  rsp_col,
   output logic [bf3_pkg::COMP_W-1:0]   rsp_red,
   output logic [bf3_pkg::COMP_W-1:0]   rsp_green,
   output logic [bf3_pkg::COMP_W-1:0]   rsp_blue,
   output logic                         rsp_run_last,
   output logic                         rsp_frame_done
);

   localparam int CB         = COMPONENT_BITS;
   localparam int ADDR_W     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int PIX_W      = 3 * CB;
   localparam int LINE_W     = 2 * PIX_W;
   localparam int COL_W      = CB + 2;
   localparam int SUM_W      = CB + 4;
   localparam int PROD_W     = SUM_W + bf3_pkg::RECIP_W;
   localparam int RESET_SIDE = (MAX_SIDE < bf3_pkg::SIDE_RESET) ? MAX_SIDE : bf3_pkg::SIDE_RESET;
   localparam logic [ADDR_W-1:0] RESET_LAST = ADDR_W'(RESET_SIDE - 1);
   localparam logic [ADDR_W-1:0] MAX_LAST   = ADDR_W'(MAX_SIDE - 1);

   // frame position and side
   logic [ADDR_W-1:0]  last_ff, last_in;
   logic [ADDR_W-1:0]  row_ff, col_ff;
   logic               csr_fire, req_fire;

   // stage 1: pixel plus line memory read
   logic               s1_valid_ff, s1_fire;
   logic [PIX_W-1:0]   s1_pix_ff;
   logic [ADDR_W-1:0]  s1_row_ff, s1_col_ff;
   bf3_pkg::pos_type   s1_pos_ff, pos_in;
   logic [LINE_W-1:0]  line_mem [MAX_SIDE];
   logic [LINE_W-1:0]  rd_ff, wr_data;
   logic               fwd;
   logic [COL_W-1:0]   cola_in [3];
   logic [COL_W-1:0]   colb_in [3];

   // stage 2: column sums of the window, oldest column at tap 0
   logic               s2_valid_ff, s2_fire;
   logic [ADDR_W-1:0]  s2_row_ff, s2_col_ff;
   bf3_pkg::pos_type   s2_pos_ff;
   logic [COL_W-1:0]   cola_ff [3][3];
   logic [COL_W-1:0]   colb_ff [3][3];
   logic [SUM_W-1:0]   sum_in [4][3];
   bf3_pkg::div_type   div_in [4];
   logic [3:0]         mask_in;
   logic [1:0]         rows_a, rows_b, cols_x, cols_y;

   // stage 3: up to four pending results, lowest first
   logic [3:0]         s3_mask_ff;
   logic [ADDR_W-1:0]  s3_row_ff, s3_col_ff;
   logic [SUM_W-1:0]   s3_sum_ff [4][3];
   bf3_pkg::div_type   s3_div_ff [4];
   logic [3:0]         low, rest;
   logic [1:0]         sel;
   logic               s3_busy, s3_single, out_take;
   logic [ADDR_W-1:0]  sel_row, sel_col;
   logic [bf3_pkg::RECIP_W-1:0] recip;
   logic [PROD_W-1:0]  prod [3];

   // result register
   logic               rsp_valid_ff;
   logic [bf3_pkg::COORD_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [bf3_pkg::COMP_W-1:0]  rsp_mean_ff [3];
   logic               rsp_run_last_ff, rsp_frame_done_ff;

   // ---------------------------------------------------------------- control
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign s1_fire   = s1_valid_ff && (!s2_valid_ff || s2_fire);
   assign s2_fire   = s2_valid_ff && (!s3_busy || (s3_single && out_take));
   assign out_take  = !rsp_valid_ff || rsp_ready;

   // clamp the side into 1..MAX_SIDE
   always_comb begin
      if (csr_side_length == '0) begin
         last_in = '0;
      end else if (int'(csr_side_length) > MAX_SIDE) begin
         last_in = MAX_LAST;
      end else begin
         last_in = ADDR_W'(csr_side_length - 1'b1);
      end
   end

   always_comb begin
      pos_in.r_ge1  = (row_ff != '0);
      pos_in.r_ge2  = (row_ff > ADDR_W'(1));
      pos_in.c_ge1  = (col_ff != '0);
      pos_in.c_ge2  = (col_ff > ADDR_W'(1));
      pos_in.r_last = (row_ff == last_ff);
      pos_in.c_last = (col_ff == last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff     <= RESET_LAST;
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) begin
            // restart the frame
            last_ff <= last_in;
            row_ff  <= '0;
            col_ff  <= '0;
         end else if (req_fire) begin
            if (col_ff == last_ff) begin
               col_ff <= '0;
               row_ff <= (row_ff == last_ff) ? '0 : row_ff + ADDR_W'(1);
            end else begin
               col_ff <= col_ff + ADDR_W'(1);
            end
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_fire) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_fire) begin
            s3_mask_ff <= mask_in;
         end else if (s3_busy && out_take) begin
            s3_mask_ff <= rest;
         end
         if (out_take) begin
            rsp_valid_ff <= s3_busy;
         end
      end
   end

   // ---------------------------------------------------------- line memory
   // entry holds {row r-2, row r-1} for its column; shift in the new pixel
   assign wr_data = {rd_ff[PIX_W-1:0], s1_pix_ff};
   // the item leaving stage 1 writes the column being read: pass it over
   assign fwd     = s1_fire && (s1_col_ff == col_ff);

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         line_mem[s1_col_ff] <= wr_data;
      end
      if (req_fire) begin
         rd_ff <= fwd ? wr_data : line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff <= {req_blue[CB-1:0], req_green[CB-1:0], req_red[CB-1:0]};
         s1_row_ff <= row_ff;
         s1_col_ff <= col_ff;
         s1_pos_ff <= pos_in;
      end
   end

   // ------------------------------------------------------- column sums
   // set A: rows r-2..r for the results one row up, set B: rows r-1..r
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cola_in[k] = COL_W'(s1_pos_ff.r_ge2 ? rd_ff[PIX_W + k*CB +: CB] : '0)
                    + COL_W'(rd_ff[k*CB +: CB]) + COL_W'(s1_pix_ff[k*CB +: CB]);
         colb_in[k] = COL_W'(s1_pos_ff.r_ge1 ? rd_ff[k*CB +: CB] : '0)
                    + COL_W'(s1_pix_ff[k*CB +: CB]);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         for (int k = 0; k < 3; k++) begin
            cola_ff[k][0] <= cola_ff[k][1];
            cola_ff[k][1] <= cola_ff[k][2];
            cola_ff[k][2] <= cola_in[k];
            colb_ff[k][0] <= colb_ff[k][1];
            colb_ff[k][1] <= colb_ff[k][2];
            colb_ff[k][2] <= colb_in[k];
         end
         s2_row_ff <= s1_row_ff;
         s2_col_ff <= s1_col_ff;
         s2_pos_ff <= s1_pos_ff;
      end
   end

   // ---------------------------------------------------- window sums
   // results: 0 (r-1,c-1), 1 (r-1,c), 2 (r,c-1), 3 (r,c)
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_in[0][k] = SUM_W'(s2_pos_ff.c_ge2 ? cola_ff[k][0] : '0)
                      + SUM_W'(cola_ff[k][1]) + SUM_W'(cola_ff[k][2]);
         sum_in[1][k] = SUM_W'(s2_pos_ff.c_ge1 ? cola_ff[k][1] : '0) + SUM_W'(cola_ff[k][2]);
         sum_in[2][k] = SUM_W'(s2_pos_ff.c_ge2 ? colb_ff[k][0] : '0)
                      + SUM_W'(colb_ff[k][1]) + SUM_W'(colb_ff[k][2]);
         sum_in[3][k] = SUM_W'(s2_pos_ff.c_ge1 ? colb_ff[k][1] : '0) + SUM_W'(colb_ff[k][2]);
      end
      rows_a = s2_pos_ff.r_ge2 ? 2'd3 : 2'd2;
      rows_b = s2_pos_ff.r_ge1 ? 2'd2 : 2'd1;
      cols_x = s2_pos_ff.c_ge2 ? 2'd3 : 2'd2;
      cols_y = s2_pos_ff.c_ge1 ? 2'd2 : 2'd1;
      div_in[0] = bf3_pkg::div_code(rows_a, cols_x);
      div_in[1] = bf3_pkg::div_code(rows_a, cols_y);
      div_in[2] = bf3_pkg::div_code(rows_b, cols_x);
      div_in[3] = bf3_pkg::div_code(rows_b, cols_y);
      mask_in[0] = s2_pos_ff.r_ge1  && s2_pos_ff.c_ge1;
      mask_in[1] = s2_pos_ff.r_ge1  && s2_pos_ff.c_last;
      mask_in[2] = s2_pos_ff.r_last && s2_pos_ff.c_ge1;
      mask_in[3] = s2_pos_ff.r_last && s2_pos_ff.c_last;
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         s3_row_ff <= s2_row_ff;
         s3_col_ff <= s2_col_ff;
         for (int j = 0; j < 4; j++) begin
            s3_div_ff[j] <= div_in[j];
            for (int k = 0; k < 3; k++) begin
               s3_sum_ff[j][k] <= sum_in[j][k];
            end
         end
      end
   end

   // ----------------------------------------------------- result select
   always_comb begin
      low       = s3_mask_ff & (~s3_mask_ff + 4'd1);
      rest      = s3_mask_ff & ~low;
      s3_busy   = |s3_mask_ff;
      s3_single = s3_busy && (rest == '0);
      case (low)
         4'b0010: sel = 2'd1;
         4'b0100: sel = 2'd2;
         4'b1000: sel = 2'd3;
         default: sel = 2'd0;
      endcase
      sel_row = sel[1] ? s3_row_ff : s3_row_ff - ADDR_W'(1);
      sel_col = sel[0] ? s3_col_ff : s3_col_ff - ADDR_W'(1);
      recip   = bf3_pkg::recip_of(s3_div_ff[sel]);
      for (int k = 0; k < 3; k++) begin
         prod[k] = PROD_W'(s3_sum_ff[sel][k]) * PROD_W'(recip);
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && s3_busy) begin
         rsp_row_ff        <= bf3_pkg::COORD_W'(sel_row);
         rsp_col_ff        <= bf3_pkg::COORD_W'(sel_col);
         rsp_run_last_ff   <= (rest == '0);
         rsp_frame_done_ff <= (sel == 2'd3);
         for (int k = 0; k < 3; k++) begin
            rsp_mean_ff[k] <= bf3_pkg::COMP_W'(prod[k][bf3_pkg::RECIP_SHIFT +: CB]);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_col        = rsp_col_ff;
   assign rsp_red        = rsp_mean_ff[0];
   assign rsp_green      = rsp_mean_ff[1];
   assign rsp_blue       = rsp_mean_ff[2];
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_frame_done = rsp_frame_done_ff;

endmodule

@@ rtl/core/bf3_checker.sv @@
// ----------------------------------------------------------------------------
// bf3_checker
// Port-level checks of the 3x3 box filter, bound to its top level.
// ----------------------------------------------------------------------------
`include "box_filter_3x3_edge_normalized_top_assert.svh"

module bf3_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bf3_pkg::COORD_W-1:0]  rsp_row,
   input logic [bf3_pkg::COORD_W-1:0]  rsp_col,
   input logic [bf3_pkg::COMP_W-1:0]   rsp_red,
   input logic [bf3_pkg::COMP_W-1:0]   rsp_green,
   input logic [bf3_pkg::COMP_W-1:0]   rsp_blue,
   input logic                         rsp_run_last,
   input logic                         rsp_frame_done
);

   // hold a stalled result item
   `BF3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row) && $stable(rsp_col) && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_run_last) && $stable(rsp_frame_done))

   // the bottom-right pixel closes the burst of its input
   `BF3_ASSERT_IMPL(a_done_is_last, clock, reset, rsp_valid && rsp_frame_done, rsp_run_last)

   // the bottom-right pixel sits on the diagonal
   `BF3_ASSERT_IMPL(a_done_on_diag, clock, reset, rsp_valid && rsp_frame_done, rsp_row == rsp_col)

   // no result item right out of reset
   `BF3_ASSERT_IMPL(a_idle_after_reset, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind box_filter_3x3_edge_normalized_top bf3_checker u_bf3_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_row        (rsp_row),
   .rsp_col        (rsp_col),
   .rsp_red        (rsp_red),
   .rsp_green      (rsp_green),
   .rsp_blue       (rsp_blue),
   .rsp_run_last   (rsp_run_last),
   .rsp_frame_done (rsp_frame_done)
);
